// ===== design/udp_frr_pkg.sv =====
// ----------------------------------------------------------------------------
// UDP flow redirect rewrite package
// Shared types, request and result codes, and ones' complement checksum
// helpers for the redirect rewrite pipeline.
// ----------------------------------------------------------------------------
package udp_frr_pkg;

	typedef enum logic [1:0] {
		REQ_KEY  = 2'd0,
		REQ_REPL = 2'd1,
		REQ_PKT  = 2'd2,
		REQ_RSVD = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ACT_PASS     = 2'd0,
		ACT_LOOPBACK = 2'd1,
		ACT_ROUTE    = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_EXACT = 2'd1,
		KIND_WILD  = 2'd2
	} kind_t;

	localparam logic [15:0] ETH_IPV4      = 16'h0800;
	localparam logic [7:0]  PROTO_UDP     = 8'd17;
	localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;
	localparam int          MAX_SLOTS     = 16;

	typedef struct packed {
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sport;
		logic [15:0] dport;
	} tuple_t;

	function automatic logic [15:0] fold_not(input logic [33:0] acc);
		logic [33:0] a;
		a = acc;
		for (int i = 0; i < 3; i++) begin
			a = {18'd0, a[15:0]} + {16'd0, a[33:16]};
		end
		return ~a[15:0];
	endfunction

	function automatic logic [15:0] csum_adjust(input logic [15:0] check,
		input logic [31:0] old_v, input logic [31:0] new_v);
		logic [15:0] nc;
		logic [31:0] no;
		logic [33:0] acc;
		nc  = ~check;
		no  = ~old_v;
		acc = {18'd0, nc} + {2'd0, no} + {2'd0, new_v};
		return fold_not(acc);
	endfunction

endpackage

// ===== design/udp_flow_redirect_rewrite_unit.sv =====
// ----------------------------------------------------------------------------
// UDP flow redirect rewrite unit
// Matches parsed IPv4/UDP headers against a redirect table, rewrites the
// tuple and produces the new IPv4 header checksum and updated UDP checksum.
//
// Channel   Direction  Handshake      Contents
// request   in         start / busy   request type, slot, tuple, header words
// result    out        done           action, match kind, tuple, checksums
//
// One transfer is accepted in every cycle; busy is always low.
// Each transfer yields one result from the seven-stage pipeline (input
// register, match, select, three checksum update stages, merge).
// Reset clears the pipeline valid bits and the table valid bits; table
// contents are undefined until written. The receiver cannot stall, so done
// is a single-cycle strobe.
// ----------------------------------------------------------------------------
module udp_flow_redirect_rewrite_unit
	import udp_frr_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [3:0]  entry_index,
	input  logic        entry_valid,
	input  logic [31:0] src_ip,
	input  logic [31:0] dst_ip,
	input  logic [15:0] src_udp_port,
	input  logic [15:0] dst_udp_port,
	input  logic [15:0] eth_type,
	input  logic [63:0] ip_front,
	input  logic [15:0] ttl_proto,
	input  logic [15:0] udp_check_in,
	output logic        done,
	output logic [1:0]  action,
	output logic [1:0]  match_kind,
	output logic [31:0] out_src_ip,
	output logic [31:0] out_dst_ip,
	output logic [15:0] out_src_port,
	output logic [15:0] out_dst_port,
	output logic [15:0] ip_checksum,
	output logic [15:0] udp_checksum
);

	localparam int SLOTS  = (TABLE_ENTRIES < MAX_SLOTS) ? TABLE_ENTRIES : MAX_SLOTS;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	tuple_t            key_q   [SLOTS];
	tuple_t            repl_q  [SLOTS];
	logic [SLOTS-1:0]  valid_q;

	logic              accept;
	logic              in_range;
	tuple_t            in_tup;

	logic              vld_s1;
	logic [1:0]        req_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              range_s1;
	tuple_t            tup_s1;
	logic [15:0]       eth_s1;
	logic [63:0]       front_s1;
	logic [15:0]       ttlp_s1;
	logic [15:0]       udpin_s1;
	logic [SLOTS-1:0]  exact_hit;
	logic [SLOTS-1:0]  wild_hit;
	logic              ok_pkt;

	logic              vld_s2;
	logic              pkt_s2;
	logic              ok_s2;
	logic [SLOTS-1:0]  exact_s2;
	logic [SLOTS-1:0]  wild_s2;
	tuple_t            tup_s2;
	logic [63:0]       front_s2;
	logic [15:0]       ttlp_s2;
	logic [15:0]       udpin_s2;
	logic [SLOTS-1:0]  pick_vec;
	logic [SLOT_W-1:0] sel;
	logic [1:0]        kind;

	logic              vld_s3;
	logic              pkt_s3;
	logic              hit_s3;
	logic [1:0]        kind_s3;
	tuple_t            tup_s3;
	tuple_t            rep_s3;
	logic [63:0]       front_s3;
	logic [15:0]       ttlp_s3;
	logic [15:0]       udpin_s3;
	logic [19:0]       ipsum;
	logic [15:0]       udc1;

	logic              vld_s4;
	logic              pkt_s4;
	logic              hit_s4;
	logic [1:0]        kind_s4;
	tuple_t            tup_s4;
	tuple_t            rep_s4;
	logic [15:0]       udpin_s4;
	logic [19:0]       ipsum_s4;
	logic [15:0]       udc_s4;

	logic              vld_s5;
	logic              pkt_s5;
	logic              hit_s5;
	logic [1:0]        kind_s5;
	tuple_t            tup_s5;
	tuple_t            rep_s5;
	logic [15:0]       udpin_s5;
	logic [15:0]       ipc_s5;
	logic [15:0]       udc_s5;

	logic              vld_s6;
	logic              pkt_s6;
	logic              hit_s6;
	logic [1:0]        kind_s6;
	tuple_t            tup_s6;
	tuple_t            rep_s6;
	logic [15:0]       udpin_s6;
	logic [15:0]       ipc_s6;
	logic [15:0]       udc_s6;
	logic [15:0]       udc_fin;

	logic              vld_s7;
	logic [1:0]        action_s7;
	logic [1:0]        kind_s7;
	tuple_t            tup_s7;
	logic [15:0]       ipc_s7;
	logic [15:0]       udc_s7;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign in_range = {1'b0, entry_index} < 5'(SLOTS);
	assign in_tup   = '{sip: src_ip, dip: dst_ip, sport: src_udp_port, dport: dst_udp_port};

	// Key and valid writes commit at acceptance; replacement writes commit from
	// the stage-1 registers so an earlier packet still reads the old replacement.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (accept && req_type == REQ_KEY && in_range) begin
			valid_q[entry_index[SLOT_W-1:0]] <= entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_KEY && in_range) begin
			key_q[entry_index[SLOT_W-1:0]] <= in_tup;
		end
		if (vld_s1 && req_s1 == REQ_REPL && range_s1) begin
			repl_q[idx_s1] <= tup_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			exact_hit[i] = valid_q[i] && key_q[i] == tup_s1;
			wild_hit[i]  = valid_q[i] && key_q[i].dip == tup_s1.dip &&
				key_q[i].dport == tup_s1.dport && key_q[i].sip == '0 &&
				key_q[i].sport == '0;
		end
	end

	assign ok_pkt = eth_s1 == ETH_IPV4 && ttlp_s1[7:0] == PROTO_UDP;

	always_comb begin
		pick_vec = (|exact_s2) ? exact_s2 : wild_s2;
		kind     = (|exact_s2) ? KIND_EXACT : KIND_WILD;
		sel      = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (pick_vec[i]) begin
				sel = SLOT_W'(i);
			end
		end
	end

	assign ipsum = {4'd0, front_s3[63:48]} + {4'd0, front_s3[47:32]} +
		{4'd0, front_s3[31:16]} + {4'd0, front_s3[15:0]} + {4'd0, ttlp_s3} +
		{4'd0, rep_s3.sip[31:16]} + {4'd0, rep_s3.sip[15:0]} +
		{4'd0, rep_s3.dip[31:16]} + {4'd0, rep_s3.dip[15:0]};
	assign udc1 = csum_adjust(udpin_s3, tup_s3.sip, rep_s3.sip);

	assign udc_fin = (rep_s6.sport != tup_s6.sport) ?
		csum_adjust(udc_s6, {16'd0, tup_s6.sport}, {16'd0, rep_s6.sport}) : udc_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		req_s1   <= req_type;
		idx_s1   <= entry_index[SLOT_W-1:0];
		range_s1 <= in_range;
		tup_s1   <= in_tup;
		eth_s1   <= eth_type;
		front_s1 <= ip_front;
		ttlp_s1  <= ttl_proto;
		udpin_s1 <= udp_check_in;

		pkt_s2   <= req_s1 == REQ_PKT;
		ok_s2    <= ok_pkt;
		exact_s2 <= exact_hit;
		wild_s2  <= wild_hit;
		tup_s2   <= tup_s1;
		front_s2 <= front_s1;
		ttlp_s2  <= ttlp_s1;
		udpin_s2 <= udpin_s1;

		pkt_s3   <= pkt_s2;
		hit_s3   <= ok_s2 && (|pick_vec);
		kind_s3  <= kind;
		tup_s3   <= tup_s2;
		rep_s3   <= repl_q[sel];
		front_s3 <= front_s2;
		ttlp_s3  <= ttlp_s2;
		udpin_s3 <= udpin_s2;

		pkt_s4   <= pkt_s3;
		hit_s4   <= hit_s3;
		kind_s4  <= kind_s3;
		tup_s4   <= tup_s3;
		rep_s4   <= rep_s3;
		udpin_s4 <= udpin_s3;
		ipsum_s4 <= ipsum;
		udc_s4   <= udc1;

		pkt_s5   <= pkt_s4;
		hit_s5   <= hit_s4;
		kind_s5  <= kind_s4;
		tup_s5   <= tup_s4;
		rep_s5   <= rep_s4;
		udpin_s5 <= udpin_s4;
		ipc_s5   <= fold_not({14'd0, ipsum_s4});
		udc_s5   <= csum_adjust(udc_s4, tup_s4.dip, rep_s4.dip);

		pkt_s6   <= pkt_s5;
		hit_s6   <= hit_s5;
		kind_s6  <= kind_s5;
		tup_s6   <= tup_s5;
		rep_s6   <= rep_s5;
		udpin_s6 <= udpin_s5;
		ipc_s6   <= ipc_s5;
		udc_s6   <= (rep_s5.dport != tup_s5.dport) ?
			csum_adjust(udc_s5, {16'd0, tup_s5.dport}, {16'd0, rep_s5.dport}) : udc_s5;

		if (!pkt_s6) begin
			action_s7 <= ACT_PASS;
			kind_s7   <= KIND_NONE;
			tup_s7    <= '0;
			ipc_s7    <= '0;
			udc_s7    <= '0;
		end else if (!hit_s6) begin
			action_s7 <= ACT_PASS;
			kind_s7   <= KIND_NONE;
			tup_s7    <= tup_s6;
			ipc_s7    <= '0;
			udc_s7    <= udpin_s6;
		end else begin
			action_s7 <= (rep_s6.dip == LOOPBACK_ADDR) ? ACT_LOOPBACK : ACT_ROUTE;
			kind_s7   <= kind_s6;
			tup_s7    <= rep_s6;
			ipc_s7    <= ipc_s6;
			udc_s7    <= udc_fin;
		end
	end

	assign done         = vld_s7;
	assign action       = action_s7;
	assign match_kind   = kind_s7;
	assign out_src_ip   = tup_s7.sip;
	assign out_dst_ip   = tup_s7.dip;
	assign out_src_port = tup_s7.sport;
	assign out_dst_port = tup_s7.dport;
	assign ip_checksum  = ipc_s7;
	assign udp_checksum = udc_s7;

`ifndef NO_ASSERTIONS
	a_done_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 7))
		else $error("result strobe without a transfer seven cycles earlier");

	a_rewrite_has_match: assert property (@(posedge clk) disable iff (!arst_n)
		(done && action != ACT_PASS) |-> match_kind != KIND_NONE)
		else $error("rewrite reported without a match");

	a_match_has_rewrite: assert property (@(posedge clk) disable iff (!arst_n)
		(done && match_kind != KIND_NONE) |-> action != ACT_PASS)
		else $error("match reported without a rewrite");

	a_no_match_zero_ipc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && match_kind == KIND_NONE) |-> ip_checksum == 16'd0)
		else $error("header checksum set on a result without a match");
`endif

endmodule

// ===== test/udp_flow_redirect_rewrite_unit_test.sv =====
// ----------------------------------------------------------------------------
// UDP flow redirect rewrite unit testbench
// Fills the redirect table, sends directed and random packet headers through
// the unit and checks every result against a cycle-free prediction of the
// table match, tuple rewrite and checksum arithmetic.
// ----------------------------------------------------------------------------
module udp_flow_redirect_rewrite_unit_test
	import udp_frr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 100000;
	localparam int TAIL_CYCLES   = 20;
	localparam int RANDOM_ITEMS  = 1700;

	typedef struct {
		logic [1:0]  req;
		logic [3:0]  idx;
		logic        vld;
		tuple_t      tup;
		logic [15:0] eth;
		logic [63:0] front;
		logic [15:0] tp;
		logic [15:0] udp;
		bit          hold;
	} header_item_t;

	typedef struct {
		action_t     act;
		kind_t       kind;
		tuple_t      tup;
		logic [15:0] ip_csum;
		logic [15:0] udp_csum;
	} rewrite_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = '0;
	logic [3:0]  entry_index = '0;
	logic        entry_valid = 1'b0;
	logic [31:0] src_ip = '0;
	logic [31:0] dst_ip = '0;
	logic [15:0] src_udp_port = '0;
	logic [15:0] dst_udp_port = '0;
	logic [15:0] eth_type = '0;
	logic [63:0] ip_front = '0;
	logic [15:0] ttl_proto = '0;
	logic [15:0] udp_check_in = '0;
	logic        done;
	logic [1:0]  action;
	logic [1:0]  match_kind;
	logic [31:0] out_src_ip;
	logic [31:0] out_dst_ip;
	logic [15:0] out_src_port;
	logic [15:0] out_dst_port;
	logic [15:0] ip_checksum;
	logic [15:0] udp_checksum;

	udp_flow_redirect_rewrite_unit dut (.*);

	header_item_t    header_queue[$];
	rewrite_result_t rewrite_expected[$];
	header_item_t    in_flight;

	tuple_t      model_key[MAX_SLOTS];
	tuple_t      model_repl[MAX_SLOTS];
	logic        model_valid[MAX_SLOTS];

	tuple_t      gen_key[MAX_SLOTS];
	logic        gen_valid[MAX_SLOTS];
	bit          gen_repl_set[MAX_SLOTS];

	int cycle_count = 0;
	int error_count = 0;
	int result_count = 0;
	int exact_count = 0;
	int wild_count = 0;
	int loopback_count = 0;
	int burst_left = 0;
	int gap_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) cycle_count++;

	function automatic logic [15:0] ones_fold(input logic [63:0] acc);
		logic [63:0] a;
		a = acc;
		while (a[63:16] != 0)
			a = a[15:0] + a[63:16];
		return ~a[15:0];
	endfunction

	function automatic logic [15:0] incr_adjust(input logic [15:0] check,
		input logic [31:0] old_v, input logic [31:0] new_v);
		logic [15:0] nc;
		logic [31:0] no;
		logic [63:0] acc;
		nc  = ~check;
		no  = ~old_v;
		acc = nc;
		acc = acc + no + new_v;
		return ones_fold(acc);
	endfunction

	function automatic rewrite_result_t rewrite_predict(input header_item_t it);
		rewrite_result_t r;
		int              hit;
		kind_t           kind;
		tuple_t          nt;
		logic [63:0]     acc;
		logic [15:0]     uc;
		r.act = ACT_PASS;
		r.kind = KIND_NONE;
		r.tup = '0;
		r.ip_csum = '0;
		r.udp_csum = '0;
		case (it.req)
			REQ_KEY: begin
				model_key[it.idx] = it.tup;
				model_valid[it.idx] = it.vld;
			end
			REQ_REPL: begin
				model_repl[it.idx] = it.tup;
			end
			REQ_PKT: begin
				r.tup = it.tup;
				r.udp_csum = it.udp;
				if (it.eth == ETH_IPV4 && it.tp[7:0] == PROTO_UDP) begin
					hit = -1;
					kind = KIND_EXACT;
					for (int i = 0; i < MAX_SLOTS; i++)
						if (hit < 0 && model_valid[i] && model_key[i] == it.tup)
							hit = i;
					if (hit < 0) begin
						kind = KIND_WILD;
						for (int i = 0; i < MAX_SLOTS; i++)
							if (hit < 0 && model_valid[i] && model_key[i].sip == 0 &&
								model_key[i].sport == 0 && model_key[i].dip == it.tup.dip &&
								model_key[i].dport == it.tup.dport)
								hit = i;
					end
					if (hit >= 0) begin
						nt = model_repl[hit];
						acc = it.front[63:48];
						acc = acc + it.front[47:32] + it.front[31:16] + it.front[15:0] +
							it.tp + nt.sip[31:16] + nt.sip[15:0] + nt.dip[31:16] +
							nt.dip[15:0];
						uc = incr_adjust(it.udp, it.tup.sip, nt.sip);
						uc = incr_adjust(uc, it.tup.dip, nt.dip);
						if (nt.dport != it.tup.dport)
							uc = incr_adjust(uc, it.tup.dport, nt.dport);
						if (nt.sport != it.tup.sport)
							uc = incr_adjust(uc, it.tup.sport, nt.sport);
						r.act = (nt.dip == LOOPBACK_ADDR) ? ACT_LOOPBACK : ACT_ROUTE;
						r.kind = kind;
						r.tup = nt;
						r.ip_csum = ones_fold(acc);
						r.udp_csum = uc;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// A slot is only marked valid once its replacement tuple has been written.
	task automatic queue_request(input logic [1:0] req, input logic [3:0] idx,
		input logic vld, input tuple_t tup, input logic [15:0] eth,
		input logic [63:0] front, input logic [15:0] tp, input logic [15:0] udp,
		input bit hold);
		header_item_t it;
		it.req = req;
		it.idx = idx;
		it.vld = vld;
		it.tup = tup;
		it.eth = eth;
		it.front = front;
		it.tp = tp;
		it.udp = udp;
		it.hold = hold;
		if (req == REQ_KEY) begin
			it.vld = vld && gen_repl_set[idx];
			gen_key[idx] = tup;
			gen_valid[idx] = it.vld;
		end else if (req == REQ_REPL) begin
			gen_repl_set[idx] = 1'b1;
		end
		header_queue.push_back(it);
	endtask

	task automatic queue_write(input logic [1:0] req, input logic [3:0] idx,
		input logic vld, input tuple_t tup);
		queue_request(req, idx, vld, tup, 16'($urandom), {$urandom, $urandom},
			16'($urandom), 16'($urandom), 1'b0);
	endtask

	task automatic queue_packet(input tuple_t tup, input logic [15:0] eth,
		input logic [63:0] front, input logic [15:0] tp, input logic [15:0] udp,
		input bit hold);
		queue_request(REQ_PKT, 4'($urandom), 1'($urandom), tup, eth, front, tp, udp, hold);
	endtask

	function automatic logic [31:0] pick_addr();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return '1;
			2: return LOOPBACK_ADDR;
			3: return 32'h0A01_0101;
			4: return 32'hC0A8_0001;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_port();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 16'd53;
			3: return 16'd4789;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_random_item(input bit hold);
		tuple_t      t;
		int          r;
		int          s;
		logic [15:0] eth;
		logic [15:0] tp;
		logic [15:0] udp;
		r = $urandom_range(0, 99);
		t = {pick_addr(), pick_addr(), pick_port(), pick_port()};
		if (r < 3) begin
			queue_request(REQ_RSVD, 4'($urandom), 1'($urandom), {$urandom, $urandom,
				16'($urandom), 16'($urandom)}, 16'($urandom), {$urandom, $urandom},
				16'($urandom), 16'($urandom), hold);
		end else if (r < 13) begin
			queue_write(REQ_REPL, 4'($urandom), 1'($urandom), t);
		end else if (r < 25) begin
			if ($urandom_range(0, 9) < 4) begin
				t.sip = '0;
				t.sport = '0;
			end
			queue_write(REQ_KEY, 4'($urandom), $urandom_range(0, 99) < 85, t);
		end else begin
			s = $urandom_range(0, MAX_SLOTS - 1);
			r = $urandom_range(0, 99);
			if (r < 55 && gen_valid[s]) begin
				t = gen_key[s];
				if (t.sip == 0 && t.sport == 0 && $urandom_range(0, 1)) begin
					t.sip = $urandom;
					t.sport = 16'($urandom);
				end
			end else if (r >= 85) begin
				t = {$urandom, $urandom, 16'($urandom), 16'($urandom)};
			end
			eth = ($urandom_range(0, 99) < 92) ? ETH_IPV4 : 16'($urandom);
			tp = {8'($urandom), ($urandom_range(0, 99) < 92) ? PROTO_UDP : 8'($urandom)};
			case ($urandom_range(0, 19))
				0: udp = '0;
				1: udp = '1;
				default: udp = 16'($urandom);
			endcase
			queue_packet(t, eth, {$urandom, $urandom}, tp, udp, hold);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				rewrite_expected.push_back(rewrite_predict(in_flight));
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (header_queue.size() != 0 &&
					!(header_queue[0].hold && rewrite_expected.size() != 0)) begin
					in_flight = header_queue.pop_front();
					req_type <= in_flight.req;
					entry_index <= in_flight.idx;
					entry_valid <= in_flight.vld;
					src_ip <= in_flight.tup.sip;
					dst_ip <= in_flight.tup.dip;
					src_udp_port <= in_flight.tup.sport;
					dst_udp_port <= in_flight.tup.dport;
					eth_type <= in_flight.eth;
					ip_front <= in_flight.front;
					ttl_proto <= in_flight.tp;
					udp_check_in <= in_flight.udp;
					start <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		rewrite_result_t want;
		if (arst_n && done) begin
			if (rewrite_expected.size() == 0) begin
				$display("%0t: result with no transfer outstanding, actual action %h",
					$time, action);
				error_count++;
			end else begin
				want = rewrite_expected.pop_front();
				result_count++;
				if (want.kind == KIND_EXACT) exact_count++;
				if (want.kind == KIND_WILD) wild_count++;
				if (want.act == ACT_LOOPBACK) loopback_count++;
				check_field("action", want.act, action);
				check_field("match_kind", want.kind, match_kind);
				check_field("out_src_ip", want.tup.sip, out_src_ip);
				check_field("out_dst_ip", want.tup.dip, out_dst_ip);
				check_field("out_src_port", want.tup.sport, out_src_port);
				check_field("out_dst_port", want.tup.dport, out_dst_port);
				check_field("ip_checksum", want.ip_csum, ip_checksum);
				check_field("udp_checksum", want.udp_csum, udp_checksum);
			end
		end
	end

	initial begin
		tuple_t k0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			model_valid[i] = 1'b0;
			gen_valid[i] = 1'b0;
			gen_repl_set[i] = 1'b0;
		end
		k0 = {32'hC0A8_0105, 32'h0A01_0101, 16'd5000, 16'd53};

		queue_packet('1, ETH_IPV4, '1, {8'hFF, PROTO_UDP}, '1, 1'b0);
		queue_write(REQ_REPL, 4'd0, 1'b0, {32'h0A00_0001, LOOPBACK_ADDR, 16'd1000, 16'd2000});
		queue_write(REQ_KEY, 4'd0, 1'b1, k0);
		queue_write(REQ_REPL, 4'd3, 1'b1, '1);
		queue_write(REQ_KEY, 4'd3, 1'b1, {32'h0, 32'h0A01_0101, 16'd0, 16'd53});
		queue_write(REQ_REPL, 4'd1, 1'b0, {32'hAC10_0009, 32'h0A09_0909, 16'd5000, 16'd53});
		queue_write(REQ_KEY, 4'd1, 1'b1, {32'h0102_0304, 32'h0A01_0101, 16'd5000, 16'd53});
		queue_packet(k0, ETH_IPV4, 64'h4500_0054_1234_4000, {8'd64, PROTO_UDP}, 16'h1234, 1'b1);
		queue_packet({32'h0808_0808, 32'h0A01_0101, 16'd777, 16'd53}, ETH_IPV4,
			64'h4500_0030_0001_0000, {8'd1, PROTO_UDP}, '0, 1'b0);
		queue_packet({32'h0102_0304, 32'h0A01_0101, 16'd5000, 16'd53}, ETH_IPV4,
			{$urandom, $urandom}, {8'd128, PROTO_UDP}, '0, 1'b0);
		queue_packet(k0, 16'h86DD, 64'h4500_0054_1234_4000, {8'd64, PROTO_UDP}, 16'h1234, 1'b0);
		queue_packet(k0, ETH_IPV4, 64'h4500_0054_1234_4000, {8'd64, 8'd6}, 16'h1234, 1'b0);
		queue_request(REQ_RSVD, 4'd9, 1'b1, '1, ETH_IPV4, '1, '1, '1, 1'b0);
		queue_write(REQ_REPL, 4'd0, 1'b0, '0);
		queue_packet(k0, ETH_IPV4, 64'h4500_0054_1234_4000, {8'd64, PROTO_UDP}, '1, 1'b0);
		queue_write(REQ_KEY, 4'd0, 1'b0, k0);
		queue_packet(k0, ETH_IPV4, 64'h4500_0054_1234_4000, {8'd64, PROTO_UDP}, 16'h1234, 1'b0);
		queue_write(REQ_REPL, 4'd15, 1'b0, {32'h0, LOOPBACK_ADDR, 16'h0, 16'hFFFF});
		queue_write(REQ_KEY, 4'd15, 1'b1, '1);
		queue_packet('1, ETH_IPV4, '0, {8'd0, PROTO_UDP}, 16'h8000, 1'b0);
		queue_packet('0, 16'h0, '0, 16'h0, '0, 1'b0);
		queue_packet({32'h0102_0304, 32'h0A01_0101, 16'd5000, 16'd53}, ETH_IPV4, '0,
			{8'hFF, PROTO_UDP}, 16'hFFFE, 1'b0);

		for (int n = 0; n < RANDOM_ITEMS; n++)
			queue_random_item(n % 400 == 0);

		wait (arst_n);
		while ((header_queue.size() != 0 || start || rewrite_expected.size() != 0) &&
			cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				rewrite_expected.size());
			$display("RESULT: ERROR");
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			if (rewrite_expected.size() != 0) begin
				$display("%0t: %0d expected results never arrived", $time,
					rewrite_expected.size());
				error_count++;
			end
			$display("Checked %0d results: %0d exact and %0d wildcard rewrites,", result_count,
				exact_count, wild_count);
			$display("%0d to loopback, the rest table writes or headers passed through.",
				loopback_count);
			if (error_count == 0)
				$display("RESULT: OK");
			else
				$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
